// ===== rtl/pst_pkg.sv =====
package pst_pkg;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_DISP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_RUN   = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  localparam int unsigned DelayW     = 20;
  localparam int unsigned StepW      = 10;
  localparam int unsigned RunsW      = 8;
  localparam int unsigned SlotW      = 3;
  localparam logic [RunsW-1:0] RunsMax   = 8'd255;
  localparam logic [StepW-1:0] StepReset = 10'd10;

  // controller -> datapath
  typedef struct packed {
    logic load;  // latch the incoming word, set up the slot index
    logic exec;  // apply the latched operation to the current slot
    logic step;  // advance to the next slot
    logic emit;  // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic idx_zero;
    logic idx_end;
    logic cur_pend;
    logic any_pend;
    logic above_pend;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/periodic_task_tick_scheduler_core.sv =====
// Add and delete are accepted, then update the slot; add also waits for a free output register, and its word is
// registered at the update edge and valid in the cycle after it.
// Tick walks all slots in turn, from slot 0 to the last.
// Dispatch walks one slot per cycle, holding at a pending slot while the output stalls.
// Throughput: one operation at a time; set by the single slot-walk index.
// Reset: all slots empty, next free slot 0, tick step 10, no output word pending.
module periodic_task_tick_scheduler_core import pst_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_operation_i,
  input  logic [DelayW-1:0] in_first_delay_i,
  input  logic [DelayW-1:0] in_period_i,
  input  logic [SlotW-1:0]  in_slot_i,
  input  logic              cfg_we_i,
  input  logic [StepW-1:0]  cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        out_status_o,
  output logic [SlotW-1:0]  out_slot_res_o,
  output logic              out_last_o
);

  cmd_t cmd;
  sts_t sts;

  pst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_operation_i   (in_operation_i),
    .in_first_delay_i (in_first_delay_i),
    .in_period_i      (in_period_i),
    .in_slot_i        (in_slot_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_status_o     (out_status_o),
    .out_slot_res_o   (out_slot_res_o),
    .out_last_o       (out_last_o)
  );

endmodule

// ===== rtl/pst_ctrl.sv =====
module pst_ctrl import pst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.op)
          OP_ADD: begin
            if (sts_i.out_free) begin
              cmd_o.exec = 1'b1;
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
          OP_DEL: begin
            cmd_o.exec = 1'b1;
            state_d    = S_IDLE;
          end
          OP_TICK: begin
            cmd_o.exec = 1'b1;
            if (sts_i.idx_end) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.step = 1'b1;
            end
          end
          OP_DISP: begin
            if (sts_i.idx_zero && !sts_i.any_pend) begin
              // nothing pending anywhere: single "nothing ready" word
              if (sts_i.out_free) begin
                cmd_o.emit = 1'b1;
                state_d    = S_IDLE;
              end
            end else if (sts_i.cur_pend) begin
              if (sts_i.out_free) begin
                cmd_o.exec = 1'b1;
                cmd_o.emit = 1'b1;
                if (sts_i.above_pend) begin
                  cmd_o.step = 1'b1;
                end else begin
                  state_d = S_IDLE;
                end
              end
            end else begin
              // a later slot is known to be pending
              cmd_o.step = 1'b1;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/pst_dp.sv =====
module pst_dp import pst_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        in_operation_i,
  input  logic [DelayW-1:0] in_first_delay_i,
  input  logic [DelayW-1:0] in_period_i,
  input  logic [SlotW-1:0]  in_slot_i,
  input  logic              cfg_we_i,
  input  logic [StepW-1:0]  cfg_wdata_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [1:0]        out_status_o,
  output logic [SlotW-1:0]  out_slot_res_o,
  output logic              out_last_o
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [StepW-1:0]  step_q;
  op_e               op_q;
  logic [DelayW-1:0] fdel_q, per_in_q;
  logic [SlotW-1:0]  slot_q;
  logic [CW-1:0]     idx_q, next_unused_q;

  logic              occ_q  [SLOTS];
  logic [DelayW-1:0] dly_q  [SLOTS];
  logic [DelayW-1:0] per_q  [SLOTS];
  logic [RunsW-1:0]  pend_q [SLOTS];

  logic              out_valid_q, out_last_q;
  status_e           out_status_q;
  logic [SlotW-1:0]  out_slot_q;

  logic [SW-1:0]     idx_w;
  logic              cur_occ;
  logic [DelayW-1:0] cur_dly, cur_per;
  logic [RunsW-1:0]  cur_pend;
  logic [SLOTS-1:0]  pnz, above;
  logic              full, del_ok, out_free;

  logic              wr;
  logic              nxt_occ;
  logic [DelayW-1:0] nxt_dly, nxt_per;
  logic [RunsW-1:0]  nxt_pend;

  status_e           res_status;
  logic [SlotW-1:0]  res_slot;
  logic              res_last;

  assign idx_w    = idx_q[SW-1:0];
  assign cur_occ  = occ_q[idx_w];
  assign cur_dly  = dly_q[idx_w];
  assign cur_per  = per_q[idx_w];
  assign cur_pend = pend_q[idx_w];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      pnz[i]   = (pend_q[i] != '0);
      above[i] = pnz[i] && (CW'(i) > idx_q);
    end
  end

  assign full     = (next_unused_q == CW'(SLOTS));
  assign del_ok   = ({3'b000, slot_q} < 6'(SLOTS)) && cur_occ;
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.op         = op_q;
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.idx_end    = (idx_q == CW'(SLOTS - 1));
  assign sts_o.cur_pend   = pnz[idx_w];
  assign sts_o.any_pend   = |pnz;
  assign sts_o.above_pend = |above;
  assign sts_o.out_free   = out_free;

  // entry update for the current slot
  always_comb begin
    wr       = 1'b0;
    nxt_occ  = cur_occ;
    nxt_dly  = cur_dly;
    nxt_per  = cur_per;
    nxt_pend = cur_pend;
    case (op_q)
      OP_ADD: begin
        if (!full) begin
          wr       = 1'b1;
          nxt_occ  = 1'b1;
          nxt_dly  = fdel_q;
          nxt_per  = per_in_q;
          nxt_pend = '0;
        end
      end
      OP_DEL: begin
        if (del_ok) begin
          wr       = 1'b1;
          nxt_occ  = 1'b0;
          nxt_dly  = '0;
          nxt_per  = '0;
          nxt_pend = '0;
        end
      end
      OP_TICK: begin
        if (cur_occ) begin
          wr = 1'b1;
          if (cur_dly == '0) begin
            if (cur_pend != RunsMax) begin
              nxt_pend = cur_pend + 1'b1;
            end
            if (cur_per != '0) begin
              nxt_dly = cur_per;
            end
          end else if (cur_dly > {{(DelayW-StepW){1'b0}}, step_q}) begin
            nxt_dly = cur_dly - {{(DelayW-StepW){1'b0}}, step_q};
          end else begin
            nxt_dly = '0;
          end
        end
      end
      default: begin
        if (cur_pend != '0) begin
          wr = 1'b1;
          if (cur_per == '0) begin
            // one-shot task: free the slot, drop remaining runs
            nxt_occ  = 1'b0;
            nxt_dly  = '0;
            nxt_per  = '0;
            nxt_pend = '0;
          end else begin
            nxt_pend = cur_pend - 1'b1;
          end
        end
      end
    endcase
  end

  always_comb begin
    res_status = ST_NONE;
    res_slot   = '0;
    res_last   = 1'b1;
    case (op_q)
      OP_ADD: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_ADDED;
          res_slot   = SlotW'(idx_q);
        end
      end
      OP_DISP: begin
        if (pnz[idx_w]) begin
          res_status = ST_RUN;
          res_slot   = SlotW'(idx_q);
          res_last   = !(|above);
        end
      end
      default: res_status = ST_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        occ_q[i]  <= 1'b0;
        dly_q[i]  <= '0;
        per_q[i]  <= '0;
        pend_q[i] <= '0;
      end
    end else if (cmd_i.exec && wr) begin
      occ_q[idx_w]  <= nxt_occ;
      dly_q[idx_w]  <= nxt_dly;
      per_q[idx_w]  <= nxt_per;
      pend_q[idx_w] <= nxt_pend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= StepReset;
      next_unused_q <= '0;
      idx_q         <= '0;
      op_q          <= OP_ADD;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (cmd_i.exec && (op_q == OP_ADD) && !full) begin
        next_unused_q <= next_unused_q + 1'b1;
      end
      if (cmd_i.load) begin
        op_q <= op_e'(in_operation_i);
        case (op_e'(in_operation_i))
          OP_ADD:  idx_q <= next_unused_q;
          OP_DEL:  idx_q <= CW'(in_slot_i);
          default: idx_q <= '0;
        endcase
      end else if (cmd_i.step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fdel_q   <= in_first_delay_i;
      per_in_q <= in_period_i;
      slot_q   <= in_slot_i;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_slot_res_o = out_slot_q;
  assign out_last_o     = out_last_q;

endmodule
